// ----- design/wav_header_chunk_parser_top_defines.svh -----
// ---------------------------------------------------------------------------
// WAV header parser assertion macros
// Clocked, reset-qualified property wrapper and an assertion shorthand
// ---------------------------------------------------------------------------
`ifndef WAV_HEADER_CHUNK_PARSER_TOP_DEFINES_SVH
`define WAV_HEADER_CHUNK_PARSER_TOP_DEFINES_SVH

// property sampled on the rising clock edge, switched off while in reset
`define WAVHP_PROP(p) @(posedge clock) disable iff (reset) (p)

// labelled assertion reporting through $error
`define WAVHP_ASSERT(label, p, msg) \
   label: assert property (`WAVHP_PROP(p)) else $error(msg);

`endif

// ----- design/wavhp_pkg.sv -----
// ---------------------------------------------------------------------------
// WAV header parser package
// Chunk ids, field offsets, phase encoding and divider interface types
// ---------------------------------------------------------------------------
`default_nettype none

package wavhp_pkg;

   // widths of the sample-count division
   localparam int unsigned DIVIDEND_W = 32;
   localparam int unsigned DIVISOR_W  = 29;   // (16-bit bits / 8) x 16-bit channels
   localparam int unsigned QCNT_W     = 5;    // one quotient bit per cycle

   // chunk ids, first byte in the low bits
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;

   // stream layout
   localparam logic [31:0] PREAMBLE_LEN = 32'd12;
   localparam logic [31:0] FMT_BODY_LEN = 32'd16;
   localparam logic [2:0]  HDR_LAST     = 3'd7;

   // byte offsets inside the fmt body
   localparam logic [3:0] FMT_CH_LO   = 4'd2;
   localparam logic [3:0] FMT_CH_HI   = 4'd3;
   localparam logic [3:0] FMT_RATE_0  = 4'd4;
   localparam logic [3:0] FMT_RATE_1  = 4'd5;
   localparam logic [3:0] FMT_RATE_2  = 4'd6;
   localparam logic [3:0] FMT_RATE_3  = 4'd7;
   localparam logic [3:0] FMT_BITS_LO = 4'd14;
   localparam logic [3:0] FMT_BITS_HI = 4'd15;

   // header byte positions
   localparam logic [2:0] HDR_ID_0   = 3'd0;
   localparam logic [2:0] HDR_ID_1   = 3'd1;
   localparam logic [2:0] HDR_ID_2   = 3'd2;
   localparam logic [2:0] HDR_ID_3   = 3'd3;
   localparam logic [2:0] HDR_SIZE_0 = 3'd4;
   localparam logic [2:0] HDR_SIZE_1 = 3'd5;
   localparam logic [2:0] HDR_SIZE_2 = 3'd6;

   typedef enum logic [6:0] {
      PH_PREAMBLE = 7'b000_0001,
      PH_HEADER   = 7'b000_0010,
      PH_FMT      = 7'b000_0100,
      PH_SKIP     = 7'b000_1000,
      PH_DONE     = 7'b001_0000,
      PH_MUL      = 7'b010_0000,
      PH_DIV      = 7'b100_0000
   } phase_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- design/wavhp_div.sv -----
// ---------------------------------------------------------------------------
// WAV header parser divider
// Restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module wavhp_div (
   input  logic                   clock,
   input  logic                   reset,
   input  wavhp_pkg::div_req_type div_req,
   output wavhp_pkg::div_rsp_type div_rsp
);
   import wavhp_pkg::*;

   logic                  busy_ff, busy_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W+1:0]  rem_sh;
   logic [DIVISOR_W+1:0]  rem_diff;
   logic                  fits;

   // shift in the next dividend bit and trial-subtract
   assign rem_sh   = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign rem_diff = rem_sh - {2'b00, dvs_ff};
   assign fits     = (rem_sh >= {2'b00, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[DIVISOR_W:0] : rem_sh[DIVISOR_W:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - QCNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ----- design/wav_header_chunk_parser_top.sv -----
// Header bytes, fmt bytes and skipped bytes are taken one per cycle unless
// the output stalls. After the last size byte of a data chunk header, the
// frame-size multiply is registered, the divider is loaded, 32 divider
// steps run and the result register is loaded; input is held off meanwhile.
// A stream-end result is registered in the cycle after the last byte.
// Synchronous active-high reset returns to the preamble with zeroed fmt fields.
// ---------------------------------------------------------------------------
// WAV header parser top level
// Walks RIFF chunks byte by byte, keeps fmt fields, reports the sample count
// ---------------------------------------------------------------------------
`default_nettype none

module wav_header_chunk_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_req,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_channels,
   output logic [15:0] rsp_bits_per_sample,
   output logic [31:0] rsp_num_samples,
   output logic        rsp_end_reason
);
   import wavhp_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [31:0]          cnt_ff, cnt_in;
   logic [31:0]          chunk_id_ff, chunk_id_in;
   logic [31:0]          chunk_size_ff, chunk_size_in;
   logic [31:0]          held_rate_ff, held_rate_in;
   logic [15:0]          held_ch_ff, held_ch_in;
   logic [15:0]          held_bits_ff, held_bits_in;
   logic                 last_pend_ff, last_pend_in;
   logic                 div_go_ff, div_go_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_rate_ff, rsp_rate_in;
   logic [15:0]          rsp_ch_ff, rsp_ch_in;
   logic [15:0]          rsp_bits_ff, rsp_bits_in;
   logic [31:0]          rsp_num_ff, rsp_num_in;
   logic                 rsp_reason_ff, rsp_reason_in;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic                 accept;
   logic                 out_free;
   logic                 in_parse;
   logic                 emit_data;
   logic [31:0]          cnt_inc;
   logic [31:0]          cnt_dec;
   logic [31:0]          size_full;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_parse  = (phase_ff == PH_PREAMBLE) || (phase_ff == PH_HEADER) ||
                      (phase_ff == PH_FMT) || (phase_ff == PH_SKIP) ||
                      (phase_ff == PH_DONE);
   assign req_stall = !(in_parse && out_free);
   assign accept    = req_valid && !req_stall;

   assign cnt_inc   = cnt_ff + 32'd1;
   assign cnt_dec   = (cnt_ff != '0) ? cnt_ff - 32'd1 : '0;
   assign size_full = {req_byte_req, chunk_size_ff[23:0]};

   // sample-count divider
   wavhp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // chunk walker and result sequencing
   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      chunk_id_in   = chunk_id_ff;
      chunk_size_in = chunk_size_ff;
      held_rate_in  = held_rate_ff;
      held_ch_in    = held_ch_ff;
      held_bits_in  = held_bits_ff;
      last_pend_in  = last_pend_ff;
      div_go_in     = div_go_ff;
      divisor_in    = divisor_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_rate_in   = rsp_rate_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_bits_in   = rsp_bits_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_reason_in = rsp_reason_ff;
      emit_data     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = chunk_size_ff;
      div_req.divisor  = divisor_ff;

      unique case (phase_ff)
         PH_PREAMBLE: begin
            if (accept) begin
               cnt_in = cnt_inc;
               if (cnt_inc >= PREAMBLE_LEN) begin
                  phase_in = PH_HEADER;
                  cnt_in   = '0;
               end
            end
         end
         PH_HEADER: begin
            if (accept) begin
               cnt_in = cnt_inc;
               case (cnt_ff[2:0])
                  HDR_ID_0:   chunk_id_in[7:0]     = req_byte_req;
                  HDR_ID_1:   chunk_id_in[15:8]    = req_byte_req;
                  HDR_ID_2:   chunk_id_in[23:16]   = req_byte_req;
                  HDR_ID_3:   chunk_id_in[31:24]   = req_byte_req;
                  HDR_SIZE_0: chunk_size_in[7:0]   = req_byte_req;
                  HDR_SIZE_1: chunk_size_in[15:8]  = req_byte_req;
                  HDR_SIZE_2: chunk_size_in[23:16] = req_byte_req;
                  default:    chunk_size_in        = size_full;
               endcase
               if (cnt_ff[2:0] == HDR_LAST) begin
                  cnt_in = '0;
                  if (chunk_id_ff == ID_FMT) begin
                     phase_in     = PH_FMT;
                     held_rate_in = '0;
                     held_ch_in   = '0;
                     held_bits_in = '0;
                  end else if (chunk_id_ff == ID_DATA) begin
                     phase_in     = PH_MUL;
                     last_pend_in = req_last_byte;
                     emit_data    = 1'b1;
                  end else if (size_full != '0) begin
                     phase_in = PH_SKIP;
                     cnt_in   = size_full;
                  end
               end
            end
         end
         PH_FMT: begin
            if (accept) begin
               cnt_in = cnt_inc;
               case (cnt_ff[3:0])
                  FMT_CH_LO:   held_ch_in[7:0]      = req_byte_req;
                  FMT_CH_HI:   held_ch_in[15:8]     = req_byte_req;
                  FMT_RATE_0:  held_rate_in[7:0]    = req_byte_req;
                  FMT_RATE_1:  held_rate_in[15:8]   = req_byte_req;
                  FMT_RATE_2:  held_rate_in[23:16]  = req_byte_req;
                  FMT_RATE_3:  held_rate_in[31:24]  = req_byte_req;
                  FMT_BITS_LO: held_bits_in[7:0]    = req_byte_req;
                  FMT_BITS_HI: held_bits_in[15:8]   = req_byte_req;
                  default:     ;
               endcase
               if (cnt_ff[3:0] == FMT_BITS_HI) begin
                  if (chunk_size_ff > FMT_BODY_LEN) begin
                     phase_in = PH_SKIP;
                     cnt_in   = chunk_size_ff - FMT_BODY_LEN;
                  end else begin
                     phase_in = PH_HEADER;
                     cnt_in   = '0;
                  end
               end
            end
         end
         PH_SKIP: begin
            if (accept) begin
               cnt_in = cnt_dec;
               if (cnt_dec == '0) begin
                  phase_in = PH_HEADER;
               end
            end
         end
         PH_DONE: begin
         end
         PH_MUL: begin
            // bytes per frame, registered ahead of the divider
            divisor_in = DIVISOR_W'({16'd0, held_bits_ff[15:3]} *
                                    {13'd0, held_ch_ff});
            phase_in   = PH_DIV;
            div_go_in  = 1'b0;
         end
         PH_DIV: begin
            if (!div_go_ff) begin
               div_req.start = 1'b1;
               div_go_in     = 1'b1;
            end else if (!div_rsp.busy && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_rate_in   = held_rate_ff;
               rsp_ch_in     = held_ch_ff;
               rsp_bits_in   = held_bits_ff;
               rsp_num_in    = (divisor_ff == '0) ? '0 : div_rsp.quotient;
               rsp_reason_in = 1'b0;
               div_go_in     = 1'b0;
               phase_in      = PH_DONE;
               if (last_pend_ff) begin
                  phase_in      = PH_PREAMBLE;
                  cnt_in        = '0;
                  chunk_id_in   = '0;
                  chunk_size_in = '0;
                  held_rate_in  = '0;
                  held_ch_in    = '0;
                  held_bits_in  = '0;
                  last_pend_in  = 1'b0;
               end
            end
         end
         default: phase_in = PH_DONE;
      endcase

      // last byte: report what was found unless already done, then start over
      if (accept && req_last_byte && !emit_data) begin
         if (phase_ff != PH_DONE) begin
            rsp_valid_in  = 1'b1;
            rsp_rate_in   = held_rate_in;
            rsp_ch_in     = held_ch_in;
            rsp_bits_in   = held_bits_in;
            rsp_num_in    = '0;
            rsp_reason_in = 1'b1;
         end
         phase_in      = PH_PREAMBLE;
         cnt_in        = '0;
         chunk_id_in   = '0;
         chunk_size_in = '0;
         held_rate_in  = '0;
         held_ch_in    = '0;
         held_bits_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PREAMBLE;
         cnt_ff       <= '0;
         held_rate_ff <= '0;
         held_ch_ff   <= '0;
         held_bits_ff <= '0;
         last_pend_ff <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         held_rate_ff <= held_rate_in;
         held_ch_ff   <= held_ch_in;
         held_bits_ff <= held_bits_in;
         last_pend_ff <= last_pend_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      chunk_id_ff   <= chunk_id_in;
      chunk_size_ff <= chunk_size_in;
      divisor_ff    <= divisor_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_bits_ff   <= rsp_bits_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_reason_ff <= rsp_reason_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sample_rate     = rsp_rate_ff;
   assign rsp_channels        = rsp_ch_ff;
   assign rsp_bits_per_sample = rsp_bits_ff;
   assign rsp_num_samples     = rsp_num_ff;
   assign rsp_end_reason      = rsp_reason_ff;

endmodule

`default_nettype wire

// ----- design/wavhp_checker.sv -----
// ---------------------------------------------------------------------------
// WAV header parser port checker
// Watches the top-level ports over time; bound to the top level below
// ---------------------------------------------------------------------------
`default_nettype none

`include "wav_header_chunk_parser_top_defines.svh"

module wavhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_num_samples,
   input logic        rsp_end_reason
);

   // a waiting item stays offered
   `WAVHP_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid,
      "result dropped while stalled")

   // a waiting item keeps its sample count
   `WAVHP_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_num_samples),
      "result changed while stalled")

   // a stream-end item never carries a sample count
   `WAVHP_ASSERT(a_end_zero, rsp_valid && rsp_end_reason |-> rsp_num_samples == 32'd0,
      "stream-end item with samples")

   // a fresh stream-end item follows an accepted last byte
   `WAVHP_ASSERT(a_end_cause,
      rsp_valid && rsp_end_reason && !$past(rsp_valid && rsp_stall) |->
         $past(req_valid && !req_stall && req_last_byte),
      "stream-end item without last byte")

endmodule

bind wav_header_chunk_parser_top wavhp_checker u_wavhp_checker (.*);

`default_nettype wire
